// ----- hdl/rab_pkg.sv -----
// Shared types, constants and angle table for the range and bearing pipeline.
`timescale 1ns / 1ps

package rab_pkg;

    localparam int CFG_W        = 24;  // widest configuration register
    localparam int OFS_W        = 16;  // distance offset width
    localparam int SPAN_W       = 24;  // scaled span width
    localparam int SQ_FRAC      = 8;   // fraction bits of the pixel lengths
    localparam int PRE_SHIFT    = 14;  // CORDIC input prescale
    localparam int CORDIC_STEPS = 16;
    localparam int ZW           = 26;  // angle accumulator, 2^-16 degree
    localparam int BRG_W        = 16;
    localparam int DIST_W       = 32;
    localparam int ANG_SHIFT    = 9;   // 2^-16 degree down to 1/128 degree
    localparam int ANG_ROUND    = 256;

    localparam logic signed [ZW-1:0] DEG90     = ZW'(5898240);
    localparam logic signed [ZW-1:0] DEG180    = ZW'(11796480);
    localparam logic [BRG_W-1:0]     FULL_TURN = BRG_W'(46080);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_ON_OWN    = 2'd2,
        ST_REF_ZERO  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CFG_REF_X1   = 3'd0,
        CFG_REF_Y1   = 3'd1,
        CFG_REF_X2   = 3'd2,
        CFG_REF_Y2   = 3'd3,
        CFG_OWN_X    = 3'd4,
        CFG_OWN_Y    = 3'd5,
        CFG_SPAN     = 3'd6,
        CFG_OFFSET   = 3'd7
    } cfg_idx_t;

    // Per-item sideband that rides along the whole chain.
    typedef struct packed {
        status_t                  status;
        logic                     left;     // dx <= 0
        logic signed [OFS_W-1:0]  offset;
        logic [BRG_W-1:0]         bearing;  // filled in after the CORDIC
    } side_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                0:       r = ZW'(2949120);
                1:       r = ZW'(1740967);
                2:       r = ZW'(919879);
                3:       r = ZW'(466945);
                4:       r = ZW'(234379);
                5:       r = ZW'(117304);
                6:       r = ZW'(58666);
                7:       r = ZW'(29335);
                8:       r = ZW'(14668);
                9:       r = ZW'(7334);
                10:      r = ZW'(3667);
                11:      r = ZW'(1833);
                12:      r = ZW'(917);
                13:      r = ZW'(458);
                14:      r = ZW'(229);
                15:      r = ZW'(115);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- hdl/rab_root_cell.sv -----
// Cell: a square-root step on both lengths; one CORDIC rotation if STEP<16.
`timescale 1ns / 1ps

module rab_root_cell #(
    parameter int RB   = 21,
    parameter int CW   = 30,
    parameter int STEP = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  rab_pkg::side_t             in_side,
    input  logic [2*RB-1:0]            in_dv,
    input  logic [RB:0]                in_drem,
    input  logic [RB-1:0]              in_droot,
    input  logic [2*RB-1:0]            in_lv,
    input  logic [RB:0]                in_lrem,
    input  logic [RB-1:0]              in_lroot,
    input  logic signed [CW-1:0]       in_x,
    input  logic signed [CW-1:0]       in_y,
    input  logic signed [rab_pkg::ZW-1:0] in_z,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rab_pkg::side_t             out_side,
    output logic [2*RB-1:0]            out_dv,
    output logic [RB:0]                out_drem,
    output logic [RB-1:0]              out_droot,
    output logic [2*RB-1:0]            out_lv,
    output logic [RB:0]                out_lrem,
    output logic [RB-1:0]              out_lroot,
    output logic signed [CW-1:0]       out_x,
    output logic signed [CW-1:0]       out_y,
    output logic signed [rab_pkg::ZW-1:0] out_z
);

    localparam int SW = 2*RB + RB + 1 + RB;

    logic                       valid_reg;
    rab_pkg::side_t             side_reg;
    logic [2*RB-1:0]            dv_reg, lv_reg, dv_next, lv_next;
    logic [RB:0]                drem_reg, lrem_reg, drem_next, lrem_next;
    logic [RB-1:0]              droot_reg, lroot_reg, droot_next, lroot_next;
    logic signed [CW-1:0]       x_reg, y_reg, x_next, y_next;
    logic signed [rab_pkg::ZW-1:0] z_reg, z_next;

    // bring down two radicand bits, try (root << 2) | 1
    function automatic logic [SW-1:0] sq_step(input logic [2*RB-1:0] v,
                                              input logic [RB:0]     rem,
                                              input logic [RB-1:0]   root);
        logic [RB+2:0] cand;
        logic [RB+2:0] trial;
        logic [RB+2:0] diff;
        logic          ge;
        begin
            cand  = {rem, v[2*RB-1:2*RB-2]};
            trial = {1'b0, root, 2'b01};
            diff  = cand - trial;
            ge    = (cand >= trial);
            return {v << 2,
                    ge ? diff[RB:0] : cand[RB:0],
                    root[RB-2:0], ge};
        end
    endfunction

    always_comb
    begin
        {dv_next, drem_next, droot_next} = sq_step(in_dv, in_drem, in_droot);
        {lv_next, lrem_next, lroot_next} = sq_step(in_lv, in_lrem, in_lroot);
    end

    generate
        if (STEP < rab_pkg::CORDIC_STEPS) begin : g_rot
            logic signed [CW-1:0] xs, ys;
            always_comb
            begin
                xs = in_x >>> STEP;
                ys = in_y >>> STEP;
                if (in_y > 0)
                begin
                    x_next = in_x + ys;
                    y_next = in_y - xs;
                    z_next = in_z + rab_pkg::atan_step(STEP);
                end
                else
                begin
                    x_next = in_x - ys;
                    y_next = in_y + xs;
                    z_next = in_z - rab_pkg::atan_step(STEP);
                end
            end
        end else begin : g_pass
            always_comb
            begin
                x_next = in_x;
                y_next = in_y;
                z_next = in_z;
            end
        end
    endgenerate

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            side_reg  <= in_side;
            dv_reg    <= dv_next;
            drem_reg  <= drem_next;
            droot_reg <= droot_next;
            lv_reg    <= lv_next;
            lrem_reg  <= lrem_next;
            lroot_reg <= lroot_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_dv    = dv_reg;
    assign out_drem  = drem_reg;
    assign out_droot = droot_reg;
    assign out_lv    = lv_reg;
    assign out_lrem  = lrem_reg;
    assign out_lroot = lroot_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

// ----- hdl/rab_div_cell.sv -----
// One chain cell: a restoring division step, one quotient bit.
`timescale 1ns / 1ps

module rab_div_cell #(
    parameter int RB = 21,
    parameter int PW = 45
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rab_pkg::side_t  in_side,
    input  logic [PW-1:0]   in_nq,     // numerator shifting out, quotient in
    input  logic [RB-1:0]   in_rem,
    input  logic [RB-1:0]   in_lf,
    output logic            out_valid,
    input  logic            out_ready,
    output rab_pkg::side_t  out_side,
    output logic [PW-1:0]   out_nq,
    output logic [RB-1:0]   out_rem,
    output logic [RB-1:0]   out_lf
);

    logic            valid_reg;
    rab_pkg::side_t  side_reg;
    logic [PW-1:0]   nq_reg, nq_next;
    logic [RB-1:0]   rem_reg, rem_next, lf_reg;
    logic [RB:0]     cand, diff;
    logic            ge;

    always_comb
    begin
        cand     = {in_rem, in_nq[PW-1]};
        diff     = cand - {1'b0, in_lf};
        ge       = (cand >= {1'b0, in_lf});
        rem_next = ge ? diff[RB-1:0] : cand[RB-1:0];
        nq_next  = {in_nq[PW-2:0], ge};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            side_reg <= in_side;
            nq_reg   <= nq_next;
            rem_reg  <= rem_next;
            lf_reg   <= in_lf;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_nq    = nq_reg;
    assign out_rem   = rem_reg;
    assign out_lf    = lf_reg;

endmodule

// ----- hdl/range_and_bearing_calc.sv -----
// Top level: range and bearing of a target pixel from an observer pixel.
`timescale 1ns / 1ps

// Fully pipelined, one target per cycle unless the output stalls. Each
// transfer on the input stream gives exactly one result transfer. Stages: an
// input register, a setup stage (squares, signs, CORDIC pre-rotation),
// COORD_BITS+9 root cells that each take one bit of both square roots and
// also run the 16 CORDIC rotations, a multiply stage (distance root times
// span, plus bearing rounding), COORD_BITS+33 divider cells giving one
// quotient bit each, and the output register. Every stage has its own valid
// bit, so bubbles squeeze out and a new target is taken while a result waits
// on the output. Target (0,0) reports not found; equal reference points
// report a zero reference; a target on the observer gives the offset alone.
// The user writes configuration only while the pipe is empty; not enforced.
module range_and_bearing_calc #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [rab_pkg::CFG_W-1:0]  cfg_data,
    // target stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,  // target_x, target_y
    // result stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [47:0]                m_axis_tdata,   // real_distance, bearing
    output logic [1:0]                 m_axis_tuser    // status
);

    localparam int C  = COORD_BITS;
    localparam int RB = C + 1 + rab_pkg::SQ_FRAC;      // root width
    localparam int RW = 2*RB;                           // radicand width
    localparam int CW = C + 18;                         // CORDIC x/y width
    localparam int PW = RB + rab_pkg::SPAN_W;           // product width
    localparam int SW = PW + 2;                         // final sum width
    localparam int ZW = rab_pkg::ZW;

    // ---------------- configuration registers ----------------
    logic [C-1:0]                ref_x1_reg, ref_y1_reg, ref_x2_reg, ref_y2_reg;
    logic [C-1:0]                own_x_reg, own_y_reg;
    logic [rab_pkg::SPAN_W-1:0]  span_reg;
    logic signed [rab_pkg::OFS_W-1:0] offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x1_reg <= '0;
            ref_y1_reg <= '0;
            ref_x2_reg <= '0;
            ref_y2_reg <= '0;
            own_x_reg  <= '0;
            own_y_reg  <= '0;
            span_reg   <= rab_pkg::SPAN_W'(256);
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (rab_pkg::cfg_idx_t'(cfg_index))
                rab_pkg::CFG_REF_X1: ref_x1_reg <= cfg_data[C-1:0];
                rab_pkg::CFG_REF_Y1: ref_y1_reg <= cfg_data[C-1:0];
                rab_pkg::CFG_REF_X2: ref_x2_reg <= cfg_data[C-1:0];
                rab_pkg::CFG_REF_Y2: ref_y2_reg <= cfg_data[C-1:0];
                rab_pkg::CFG_OWN_X:  own_x_reg  <= cfg_data[C-1:0];
                rab_pkg::CFG_OWN_Y:  own_y_reg  <= cfg_data[C-1:0];
                rab_pkg::CFG_SPAN:   span_reg   <= cfg_data[rab_pkg::SPAN_W-1:0];
                rab_pkg::CFG_OFFSET: offset_reg <= cfg_data[rab_pkg::OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic         in_valid_reg, in_ready;
    logic [C-1:0] in_tx_reg, in_ty_reg;
    logic         pre_ready;

    assign in_ready      = !in_valid_reg || pre_ready;
    assign s_axis_tready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_axis_tvalid)
        begin
            in_tx_reg <= s_axis_tdata[C-1:0];
            in_ty_reg <= s_axis_tdata[2*C-1:C];
        end
    end

    // ---------------- setup stage ----------------
    logic signed [C:0]      dx, up, lx, ly;
    logic signed [2*C+1:0]  dxx, upp, lxx, lyy;
    logic [2*C:0]           d2, l2;
    logic [C-1:0]           ax;
    logic signed [CW-1:0]   up_s, ax_s, x_init, y_init;
    logic signed [ZW-1:0]   z_init;
    rab_pkg::side_t         pre_side;

    always_comb
    begin
        dx   = $signed({1'b0, in_tx_reg}) - $signed({1'b0, own_x_reg});
        up   = $signed({1'b0, own_y_reg}) - $signed({1'b0, in_ty_reg});
        lx   = $signed({1'b0, ref_x2_reg}) - $signed({1'b0, ref_x1_reg});
        ly   = $signed({1'b0, ref_y2_reg}) - $signed({1'b0, ref_y1_reg});
        dxx  = dx * dx;
        upp  = up * up;
        lxx  = lx * lx;
        lyy  = ly * ly;
        d2   = {1'b0, dxx[2*C-1:0]} + {1'b0, upp[2*C-1:0]};
        l2   = {1'b0, lxx[2*C-1:0]} + {1'b0, lyy[2*C-1:0]};
        ax   = dx[C] ? C'(-dx) : dx[C-1:0];

        // CORDIC start; rotate by 90 degrees when the target is below
        up_s = CW'(up) <<< rab_pkg::PRE_SHIFT;
        ax_s = $signed({{(CW-C){1'b0}}, ax}) <<< rab_pkg::PRE_SHIFT;
        if (up[C])
        begin
            x_init = ax_s;
            y_init = -up_s;
            z_init = rab_pkg::DEG90;
        end
        else
        begin
            x_init = up_s;
            y_init = ax_s;
            z_init = '0;
        end

        pre_side.left    = dx[C] || (dx == '0);
        pre_side.offset  = offset_reg;
        pre_side.bearing = '0;
        if (in_tx_reg == '0 && in_ty_reg == '0)
            pre_side.status = rab_pkg::ST_NOT_FOUND;
        else if (l2 == '0)
            pre_side.status = rab_pkg::ST_REF_ZERO;
        else if (dx == '0 && up == '0)
            pre_side.status = rab_pkg::ST_ON_OWN;
        else
            pre_side.status = rab_pkg::ST_OK;
    end

    logic                  pre_valid_reg;
    rab_pkg::side_t        pre_side_reg;
    logic [RW-1:0]         pre_dv_reg, pre_lv_reg;
    logic signed [CW-1:0]  pre_x_reg, pre_y_reg;
    logic signed [ZW-1:0]  pre_z_reg;

    logic rr [0:RB];   // ready into each root cell, RB is the multiply stage
    logic rv [0:RB];

    assign pre_ready = !pre_valid_reg || rr[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (pre_ready)
            pre_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pre_ready && in_valid_reg)
        begin
            pre_side_reg <= pre_side;
            pre_dv_reg   <= {1'b0, d2, {(2*rab_pkg::SQ_FRAC){1'b0}}};
            pre_lv_reg   <= {1'b0, l2, {(2*rab_pkg::SQ_FRAC){1'b0}}};
            pre_x_reg    <= x_init;
            pre_y_reg    <= y_init;
            pre_z_reg    <= z_init;
        end
    end

    // ---------------- root / CORDIC chain ----------------
    rab_pkg::side_t        rs    [0:RB];
    logic [RW-1:0]         rdv   [0:RB];
    logic [RW-1:0]         rlv   [0:RB];
    logic [RB:0]           rdrem [0:RB];
    logic [RB:0]           rlrem [0:RB];
    logic [RB-1:0]         rdrt  [0:RB];
    logic [RB-1:0]         rlrt  [0:RB];
    logic signed [CW-1:0]  rx    [0:RB];
    logic signed [CW-1:0]  ry    [0:RB];
    logic signed [ZW-1:0]  rz    [0:RB];

    assign rv[0]    = pre_valid_reg;
    assign rs[0]    = pre_side_reg;
    assign rdv[0]   = pre_dv_reg;
    assign rlv[0]   = pre_lv_reg;
    assign rdrem[0] = '0;
    assign rlrem[0] = '0;
    assign rdrt[0]  = '0;
    assign rlrt[0]  = '0;
    assign rx[0]    = pre_x_reg;
    assign ry[0]    = pre_y_reg;
    assign rz[0]    = pre_z_reg;

    generate
        for (genvar i = 0; i < RB; i++) begin : g_root
            rab_root_cell #(.RB(RB), .CW(CW), .STEP(i)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (rv[i]),
                .in_ready  (rr[i]),
                .in_side   (rs[i]),
                .in_dv     (rdv[i]),
                .in_drem   (rdrem[i]),
                .in_droot  (rdrt[i]),
                .in_lv     (rlv[i]),
                .in_lrem   (rlrem[i]),
                .in_lroot  (rlrt[i]),
                .in_x      (rx[i]),
                .in_y      (ry[i]),
                .in_z      (rz[i]),
                .out_valid (rv[i+1]),
                .out_ready (rr[i+1]),
                .out_side  (rs[i+1]),
                .out_dv    (rdv[i+1]),
                .out_drem  (rdrem[i+1]),
                .out_droot (rdrt[i+1]),
                .out_lv    (rlv[i+1]),
                .out_lrem  (rlrem[i+1]),
                .out_lroot (rlrt[i+1]),
                .out_x     (rx[i+1]),
                .out_y     (ry[i+1]),
                .out_z     (rz[i+1])
            );
        end
    endgenerate

    // ---------------- multiply stage ----------------
    logic [ZW-1:0]              zc, zr;
    logic [rab_pkg::BRG_W-1:0]  ang;
    rab_pkg::side_t             mul_side;

    always_comb
    begin
        if (rz[RB] < 0)
            zc = '0;
        else if (rz[RB] > rab_pkg::DEG180)
            zc = rab_pkg::DEG180;
        else
            zc = rz[RB];
        zr  = zc + ZW'(rab_pkg::ANG_ROUND);
        ang = zr[rab_pkg::ANG_SHIFT +: rab_pkg::BRG_W];
        mul_side         = rs[RB];
        mul_side.bearing = rs[RB].left ? rab_pkg::FULL_TURN - ang : ang;
    end

    logic            mul_valid_reg, mul_ready;
    rab_pkg::side_t  mul_side_reg;
    logic [PW-1:0]   mul_p_reg;
    logic [RB-1:0]   mul_lf_reg;

    logic dr [0:PW];
    logic dv [0:PW];

    assign mul_ready = !mul_valid_reg || dr[0];
    assign rr[RB]    = mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (mul_ready)
            mul_valid_reg <= rv[RB];
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready && rv[RB])
        begin
            mul_side_reg <= mul_side;
            mul_p_reg    <= rdrt[RB] * span_reg;
            // a zero reference is flagged; its quotient is dropped at the output
            mul_lf_reg   <= rlrt[RB];
        end
    end

    // ---------------- divider chain ----------------
    rab_pkg::side_t  ds   [0:PW];
    logic [PW-1:0]   dnq  [0:PW];
    logic [RB-1:0]   drem [0:PW];
    logic [RB-1:0]   dlf  [0:PW];

    assign dv[0]   = mul_valid_reg;
    assign ds[0]   = mul_side_reg;
    assign dnq[0]  = mul_p_reg;
    assign drem[0] = '0;
    assign dlf[0]  = mul_lf_reg;

    generate
        for (genvar k = 0; k < PW; k++) begin : g_div
            rab_div_cell #(.RB(RB), .PW(PW)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (dv[k]),
                .in_ready  (dr[k]),
                .in_side   (ds[k]),
                .in_nq     (dnq[k]),
                .in_rem    (drem[k]),
                .in_lf     (dlf[k]),
                .out_valid (dv[k+1]),
                .out_ready (dr[k+1]),
                .out_side  (ds[k+1]),
                .out_nq    (dnq[k+1]),
                .out_rem   (drem[k+1]),
                .out_lf    (dlf[k+1])
            );
        end
    endgenerate

    // ---------------- offset, saturation, output register ----------------
    localparam logic signed [SW-1:0] DMAX = {{(SW-32){1'b0}}, 32'h7fff_ffff};
    localparam logic signed [SW-1:0] DMIN = {{(SW-32){1'b1}}, 32'h8000_0000};

    logic signed [SW-1:0]            q_s, off_s, sum;
    logic [rab_pkg::DIST_W-1:0]      sat_dist;
    rab_pkg::side_t                  fs;
    logic [rab_pkg::DIST_W-1:0]      out_dist;
    logic [rab_pkg::BRG_W-1:0]       out_brg;

    always_comb
    begin
        fs    = ds[PW];
        off_s = $signed({{(SW-rab_pkg::OFS_W){fs.offset[rab_pkg::OFS_W-1]}}, fs.offset})
                <<< FRAC_BITS;
        q_s   = (fs.status == rab_pkg::ST_OK) ? $signed({2'b00, dnq[PW]}) : '0;
        sum   = q_s + off_s;
        if (sum > DMAX)
            sat_dist = 32'h7fff_ffff;
        else if (sum < DMIN)
            sat_dist = 32'h8000_0000;
        else
            sat_dist = sum[rab_pkg::DIST_W-1:0];

        case (fs.status)
            rab_pkg::ST_OK:
            begin
                out_dist = sat_dist;
                out_brg  = fs.bearing;
            end
            rab_pkg::ST_ON_OWN:
            begin
                out_dist = sat_dist;
                out_brg  = '0;
            end
            default:
            begin
                out_dist = '0;
                out_brg  = '0;
            end
        endcase
    end

    logic                        out_valid_reg, out_ready;
    logic [1:0]                  out_status_reg;
    logic [rab_pkg::DIST_W-1:0]  out_dist_reg;
    logic [rab_pkg::BRG_W-1:0]   out_brg_reg;

    assign out_ready = !out_valid_reg || m_axis_tready;
    assign dr[PW]    = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= dv[PW];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && dv[PW])
        begin
            out_status_reg <= fs.status;
            out_dist_reg   <= out_dist;
            out_brg_reg    <= out_brg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_brg_reg, out_dist_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

// ----- verif/tb_range_and_bearing_calc.sv -----
// Self-checking testbench for the range and bearing pipeline.
`timescale 1ns / 1ps

module tb_range_and_bearing_calc;

    typedef struct {
        rab_pkg::status_t   status;
        logic signed [31:0] distance;
        logic [15:0]        bearing;
    } rab_result_t;

    // atan(2^-i) in 2^-16 degree
    localparam longint ATAN_LUT [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [23:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata;   // target_x, target_y
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;   // real_distance, bearing
    logic [1:0]   m_axis_tuser;   // status

    range_and_bearing_calc u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // shadow copy of the registers
    longint      sh_rx1, sh_ry1, sh_rx2, sh_ry2, sh_ox, sh_oy, sh_span, sh_ofs;

    logic [23:0] target_q [$];
    rab_result_t result_q [$];
    int          n_errors;
    int          n_checked;
    int          n_phases;
    bit          no_idle;
    int          src_gap;
    int          snk_gap;
    logic [23:0] cur_target;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (no_idle || r < 60)
                return 0;
            if (r < 92)
                return $urandom_range(1, 3);
            return $urandom_range(10, 40);
        end
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        begin
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= root + bitv)
                begin
                    v = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            return root;
        end
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        begin
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            return v[31:0];
        end
    endfunction

    // Angle from screen-up via vectoring CORDIC, 2^-16 degree, clamped.
    function automatic longint angle_from_up(longint up, longint ax);
        longint x, y, z, t, xs, ys;
        begin
            x = up * 16384;
            y = ax * 16384;
            z = 0;
            if (x < 0)
            begin
                t = x;
                x = y;
                y = -t;
                z = 5898240;
            end
            for (int i = 0; i < 16; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_LUT[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_LUT[i];
                end
            end
            if (z < 0)
                z = 0;
            if (z > 11796480)
                z = 11796480;
            return z;
        end
    endfunction

    function automatic rab_result_t range_bearing(logic [23:0] tgt);
        rab_result_t     r;
        longint          tx, ty, dx, up, ofs, ang;
        longint unsigned l2, d2, lf, df, q;
        begin
            tx = longint'(tgt[11:0]);
            ty = longint'(tgt[23:12]);
            r.status = rab_pkg::ST_OK;
            r.distance = '0;
            r.bearing = '0;
            l2 = (sh_rx2 - sh_rx1) * (sh_rx2 - sh_rx1) + (sh_ry2 - sh_ry1) * (sh_ry2 - sh_ry1);
            dx = tx - sh_ox;
            up = sh_oy - ty;
            ofs = sh_ofs * 256;
            if (tx == 0 && ty == 0)
                r.status = rab_pkg::ST_NOT_FOUND;
            else if (l2 == 0)
                r.status = rab_pkg::ST_REF_ZERO;
            else if (dx == 0 && up == 0)
            begin
                r.status = rab_pkg::ST_ON_OWN;
                r.distance = sat32(ofs);
            end
            else
            begin
                d2 = dx * dx + up * up;
                lf = int_sqrt(l2 << 16);
                df = int_sqrt(d2 << 16);
                q = (df * sh_span) / lf;
                r.distance = sat32(longint'(q) + ofs);
                ang = (angle_from_up(up, (dx < 0) ? -dx : dx) + 256) >>> 9;
                if (dx <= 0)
                    ang = 46080 - ang;
                r.bearing = ang[15:0];
            end
            return r;
        end
    endfunction

    // Source side: one target in flight on the bus, random gaps between transfers.
    always @(posedge clk)
    begin
        logic nv;
        nv = s_axis_tvalid;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                result_q.push_back(range_bearing(cur_target));
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (target_q.size() > 0)
                begin
                    cur_target = target_q.pop_front();
                    s_axis_tdata <= cur_target;
                    nv = 1'b1;
                    src_gap = pick_gap();
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // Sink side: compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        rab_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_checked++;
                if (result_q.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: result with nothing expected: st=%0d d=%0d b=%0d",
                                 m_axis_tuser, $signed(m_axis_tdata[31:0]), m_axis_tdata[47:32]);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (m_axis_tuser !== want.status || m_axis_tdata[31:0] !== want.distance
                        || m_axis_tdata[47:32] !== want.bearing)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("ERROR: exp st=%0d d=%0d b=%0d, got st=%0d d=%0d b=%0d",
                                     want.status, want.distance, want.bearing, m_axis_tuser,
                                     $signed(m_axis_tdata[31:0]), m_axis_tdata[47:32]);
                    end
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                snk_gap = pick_gap();
            end
        end
    end

    task automatic write_reg(rab_pkg::cfg_idx_t idx, logic [23:0] v);
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= v;
            @(posedge clk);
            cfg_we <= 1'b0;
            case (idx)
                rab_pkg::CFG_REF_X1: sh_rx1 = longint'(v[11:0]);
                rab_pkg::CFG_REF_Y1: sh_ry1 = longint'(v[11:0]);
                rab_pkg::CFG_REF_X2: sh_rx2 = longint'(v[11:0]);
                rab_pkg::CFG_REF_Y2: sh_ry2 = longint'(v[11:0]);
                rab_pkg::CFG_OWN_X:  sh_ox = longint'(v[11:0]);
                rab_pkg::CFG_OWN_Y:  sh_oy = longint'(v[11:0]);
                rab_pkg::CFG_SPAN:   sh_span = longint'(v);
                rab_pkg::CFG_OFFSET: sh_ofs = longint'($signed(v[15:0]));
                default: ;
            endcase
        end
    endtask

    // Coordinate write with junk above bit 11, which the block must drop.
    task automatic write_coord(rab_pkg::cfg_idx_t idx, int v);
        begin
            write_reg(idx, {12'($urandom), 12'(v)});
        end
    endtask

    task automatic write_all(int rx1, int ry1, int rx2, int ry2, int ox, int oy,
                             int span, int ofs);
        begin
            write_coord(rab_pkg::CFG_REF_X1, rx1);
            write_coord(rab_pkg::CFG_REF_Y1, ry1);
            write_coord(rab_pkg::CFG_REF_X2, rx2);
            write_coord(rab_pkg::CFG_REF_Y2, ry2);
            write_coord(rab_pkg::CFG_OWN_X, ox);
            write_coord(rab_pkg::CFG_OWN_Y, oy);
            write_reg(rab_pkg::CFG_SPAN, 24'(span));
            write_reg(rab_pkg::CFG_OFFSET, {8'($urandom), 16'(ofs)});
        end
    endtask

    task automatic drain();
        begin
            // sample away from the rising edge so a pop in flight is seen
            while (target_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
                @(negedge clk);
            // pipe is 70 deep; let it settle before touching registers
            repeat (100) @(posedge clk);
        end
    endtask

    function automatic logic [23:0] pack_target(int x, int y);
        return {12'(y), 12'(x)};
    endfunction

    task automatic push_random(int count);
        int r;
        begin
            for (int i = 0; i < count; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    target_q.push_back(24'd0);
                else if (r < 8)
                    target_q.push_back(pack_target(int'(sh_ox), int'(sh_oy)));
                else if (r < 30)
                    // near the observer, small angles and distances
                    target_q.push_back(pack_target(
                        int'((sh_ox + $urandom_range(0, 16) - 8) & 12'hfff),
                        int'((sh_oy + $urandom_range(0, 16) - 8) & 12'hfff)));
                else
                    target_q.push_back(24'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        n_errors = 0;
        n_checked = 0;
        n_phases = 0;
        no_idle = 1'b0;
        src_gap = 0;
        snk_gap = 0;
        cur_target = '0;
        sh_rx1 = 0; sh_ry1 = 0; sh_rx2 = 0; sh_ry2 = 0;
        sh_ox = 0; sh_oy = 0; sh_span = 256; sh_ofs = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // a few items on reset values: zero reference length
        target_q.push_back(pack_target(5, 7));
        target_q.push_back(24'd0);
        drain();

        // directed: 3-4-5 reference, observer mid screen
        write_all(0, 0, 3, 4, 2000, 2000, 5 * 256, 0);
        target_q.push_back(24'd0);
        target_q.push_back(pack_target(2000, 2000));
        target_q.push_back(pack_target(2000, 0));       // straight up
        target_q.push_back(pack_target(2000, 4095));    // straight down
        target_q.push_back(pack_target(4095, 2000));    // right
        target_q.push_back(pack_target(1, 2000));       // left
        target_q.push_back(pack_target(4095, 4095));
        target_q.push_back(pack_target(4095, 0));
        target_q.push_back(pack_target(0, 4095));
        target_q.push_back(pack_target(1, 0));
        target_q.push_back(pack_target(0, 1));
        target_q.push_back(pack_target(2001, 1999));
        target_q.push_back(pack_target(1999, 2001));
        target_q.push_back(pack_target(2001, 2000));
        target_q.push_back(pack_target(2000, 1999));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            no_idle = (ph % 3 == 2);
            case (ph)
                0: write_all(0, 0, 4095, 4095, 0, 0, 24'hffffff, 32767);   // largest span and offset
                1: write_all(4095, 4095, 4095, 4094, 4095, 4095, 0, -32768);
                2: write_all(100, 200, 100, 201, 0, 4095, 24'hffffff, -32768);
                3: write_all(4095, 0, 0, 4095, 4095, 0, 1, 0);
                4: write_all(7, 7, 7, 7, 1000, 1000, 256, 5);             // zero reference
                default: write_all($urandom_range(0, 4095), $urandom_range(0, 4095),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                                   $urandom_range(0, 24'hffffff), $urandom_range(0, 65535));
            endcase
            push_random((ph == 4) ? 40 : 260);
            drain();
            n_phases++;
        end

        $display("Checked %0d results over %0d register settings,", n_checked, n_phases + 2);
        $display("including saturation, zero span, zero reference and all four quadrants.");
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches", n_errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout with %0d results outstanding", result_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- range_and_bearing_calc.f -----
hdl/rab_pkg.sv
hdl/rab_root_cell.sv
hdl/rab_div_cell.sv
hdl/range_and_bearing_calc.sv
verif/tb_range_and_bearing_calc.sv
